/* rtl/gpr_pkg.sv */
`timescale 1ns / 1ps

package gpr_pkg;

    localparam int GPR_MAX_WIDTH  = 4096;
    localparam int GPR_SAMPLE_W   = 18;
    localparam int GPR_VSUM_W     = 22;
    localparam int GPR_TOTAL_W    = 26;
    localparam int GPR_FW_W       = 13;
    localparam int GPR_FH_W       = 16;
    localparam int GPR_ROW_W      = 15;
    localparam int GPR_COL_W      = 11;
    localparam int GPR_CFG_DATA_W = 16;
    localparam int GPR_IN_TDATA_W = 24;
    localparam int GPR_OUT_TDATA_W = 48;

    localparam logic [GPR_FW_W-1:0] GPR_WIDTH_RESET  = 13'd4096;
    localparam logic [GPR_FH_W-1:0] GPR_HEIGHT_RESET = 16'd4096;

    // configuration register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // one memory word: the four line stores at one column
    typedef logic [3:0][GPR_SAMPLE_W-1:0] gpr_word_t;

    // one decimated pixel and the border copies it stands for
    typedef struct packed {
        logic signed [GPR_SAMPLE_W-1:0] value;
        logic [GPR_ROW_W-1:0]           row;
        logic [GPR_COL_W-1:0]           col;
        logic [GPR_ROW_W-1:0]           last_row;
        logic [GPR_COL_W-1:0]           last_col;
        logic                           top;
        logic                           bottom;
        logic                           left;
        logic                           right;
    } gpr_job_t;

endpackage

/* rtl/gaussian_pyramid_reduce_unit.sv */
`timescale 1ns / 1ps

// Channel  Dir  Beat                                   Fields (lowest bit up)
// s_*      in   one input sample, row-major            tdata: sample_in [17:0]
// m_*      out  one coarse pixel or border copy        tdata: coarse_row [14:0],
//                                                        coarse_col [25:15],
//                                                        coarse_value [43:26];
//                                                      tlast: run_last
// cfg_*    in   register write, index 0 width, 1 height
//
// One sample per cycle while the input is not stalled. A sample passes the datapath in order:
// line-store read, vertical sum plus write-back, horizontal sum and rounding.
// An emitting sample yields one to nine output beats, one per cycle while m_tready is high;
// while they drain, the next emitting sample waits in the last stage and the input
// stalls behind it. After reset a clearing pass writes zero to all
// MAX_WIDTH line-store words, one per cycle; s_tready stays low meanwhile.
// Reset: asynchronous, active low, clears counters and window, sets both
// frame sizes to 4096.

module gaussian_pyramid_reduce_unit
    import gpr_pkg::*;
#(
    parameter int MAX_WIDTH = GPR_MAX_WIDTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // sample_in [17:0], zero fill
    input  logic [GPR_IN_TDATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // coarse_row [14:0], coarse_col [25:15], coarse_value [43:26], zero fill
    output logic [GPR_OUT_TDATA_W-1:0] m_tdata,
    output logic                       m_tlast,
    input  logic                       cfg_we,
    input  logic                       cfg_addr,
    input  logic [GPR_CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);           // column counter bits
    localparam int WW = CW + 1;                      // effective width bits
    localparam int FX = (WW > GPR_FW_W) ? WW : GPR_FW_W;
    localparam int RW = GPR_FH_W;

    // configuration
    logic [GPR_FW_W-1:0] frame_width_reg;
    logic [GPR_FH_W-1:0] frame_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= GPR_WIDTH_RESET;
            frame_height_reg <= GPR_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[GPR_FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[GPR_FH_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp the frame size
    logic [FX-1:0] w_cfg;
    logic [WW-1:0] w_eff;
    logic [RW-1:0] h_eff;

    always_comb
    begin
        w_cfg = FX'(frame_width_reg);
        if (w_cfg < FX'(5))
            w_eff = WW'(5);
        else if (w_cfg > FX'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(w_cfg);
        h_eff = (frame_height_reg < RW'(5)) ? RW'(5) : frame_height_reg;
    end

    // clearing pass over the line stores
    logic          clr_active_reg;
    logic [CW-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + CW'(1);
            if (clr_addr_reg == CW'(MAX_WIDTH - 1))
                clr_active_reg <= 1'b0;
        end
    end

    // pipeline control: stall only when an emitting pixel meets a busy emitter
    logic s1_valid_reg;
    logic s2_emit_reg;
    logic job_free;
    logic adv;
    logic accept;

    assign adv      = !s2_emit_reg || job_free;
    assign s_tready = adv && !clr_active_reg;
    assign accept   = s_tvalid && s_tready;

    // position counters and emission decision at the input
    logic [CW-1:0] col_cnt_reg;
    logic [RW-1:0] row_cnt_reg;
    logic [WW-1:0] col_inc;
    logic [RW:0]   row_inc;
    logic [WW-1:0] wm1_full;
    logic [CW-1:0] wm1;
    logic [RW-1:0] hm1;
    logic          emit0;
    gpr_job_t      job0;
    logic [CW-2:0] i_idx;
    logic [31:0]   i_ext;
    logic [31:0]   lc_ext;

    always_comb
    begin
        col_inc  = {1'b0, col_cnt_reg} + WW'(1);
        row_inc  = {1'b0, row_cnt_reg} + (RW+1)'(1);
        wm1_full = w_eff - WW'(1);
        wm1      = wm1_full[CW-1:0];
        hm1      = h_eff - RW'(1);

        emit0 = !row_cnt_reg[0] && !col_cnt_reg[0]
             && (row_cnt_reg >= RW'(4)) && (col_cnt_reg >= CW'(4))
             && (row_cnt_reg < h_eff) && ({1'b0, col_cnt_reg} < w_eff);

        i_idx  = col_cnt_reg[CW-1:1] - (CW-1)'(1);
        i_ext  = 32'(i_idx);
        lc_ext = 32'(wm1[CW-1:1]);

        job0.value    = '0;
        job0.row      = row_cnt_reg[RW-1:1] - GPR_ROW_W'(1);
        job0.col      = i_ext[GPR_COL_W-1:0];
        job0.last_row = hm1[RW-1:1];
        job0.last_col = lc_ext[GPR_COL_W-1:0];
        job0.top      = (row_cnt_reg == RW'(4));
        job0.bottom   = (row_cnt_reg[RW-1:1] == hm1[RW-1:1]);
        job0.left     = (col_cnt_reg == CW'(4));
        job0.right    = (col_cnt_reg[CW-1:1] == wm1[CW-1:1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (accept)
        begin
            // wrap at the end of a row, then at the end of the frame
            if (col_inc >= w_eff)
            begin
                col_cnt_reg <= '0;
                row_cnt_reg <= (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[RW-1:0];
            end
            else
            begin
                col_cnt_reg <= col_inc[CW-1:0];
            end
        end
    end

    // line stores: one word holds all four lines at one column
    gpr_word_t mem [MAX_WIDTH];
    gpr_word_t rd_word_reg;
    logic          mem_we;
    logic [CW-1:0] mem_wa;
    gpr_word_t     mem_wd;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            rd_word_reg <= mem[col_cnt_reg];
    end

    // stage 1: sample waits for its column word
    logic signed [GPR_SAMPLE_W-1:0] s1_sample_reg;
    logic [CW-1:0]                  s1_col_reg;
    logic [1:0]                     s1_lane_reg;
    logic                           s1_emit_reg;
    gpr_job_t                       s1_job_reg;
    gpr_job_t                       s2_job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_emit_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept;
            s2_emit_reg  <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_sample_reg <= signed'(s_tdata[GPR_SAMPLE_W-1:0]);
            s1_col_reg    <= col_cnt_reg;
            s1_lane_reg   <= row_cnt_reg[1:0];
            s1_emit_reg   <= emit0;
            s1_job_reg    <= job0;
            s2_job_reg    <= s1_job_reg;
        end
    end

    // vertical 1-4-6-4-1 sum; the oldest line sits in the current lane
    logic signed [GPR_SAMPLE_W-1:0] a0, a1, a2, a3;
    logic signed [GPR_VSUM_W-1:0]   vsum;
    gpr_word_t                      wb_word;

    always_comb
    begin
        a0 = signed'(rd_word_reg[s1_lane_reg]);
        a1 = signed'(rd_word_reg[s1_lane_reg + 2'd1]);
        a2 = signed'(rd_word_reg[s1_lane_reg + 2'd2]);
        a3 = signed'(rd_word_reg[s1_lane_reg + 2'd3]);
        vsum = GPR_VSUM_W'(a0) + GPR_VSUM_W'(s1_sample_reg)
             + ((GPR_VSUM_W'(a1) + GPR_VSUM_W'(a3)) <<< 2)
             + (GPR_VSUM_W'(a2) <<< 2) + (GPR_VSUM_W'(a2) <<< 1);
        wb_word = rd_word_reg;
        wb_word[s1_lane_reg] = s1_sample_reg;
    end

    // write port: clearing pass first, then the write-back of stage 1
    always_comb
    begin
        if (clr_active_reg)
        begin
            mem_we = 1'b1;
            mem_wa = clr_addr_reg;
            mem_wd = '0;
        end
        else
        begin
            mem_we = adv && s1_valid_reg;
            mem_wa = s1_col_reg;
            mem_wd = wb_word;
        end
    end

    // column window of vertical sums
    logic signed [GPR_VSUM_W-1:0] win_reg [5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 5; k++)
                win_reg[k] <= '0;
        end
        else if (adv && s1_valid_reg)
        begin
            for (int k = 0; k < 4; k++)
                win_reg[k] <= win_reg[k+1];
            win_reg[4] <= vsum;
        end
    end

    // stage 2: horizontal sum, divide by 256 rounding half up
    logic signed [GPR_TOTAL_W-1:0] total;
    logic signed [GPR_TOTAL_W-1:0] rounded;
    gpr_job_t                      job2;
    logic                          job_load;

    always_comb
    begin
        total = GPR_TOTAL_W'(win_reg[0]) + GPR_TOTAL_W'(win_reg[4])
              + ((GPR_TOTAL_W'(win_reg[1]) + GPR_TOTAL_W'(win_reg[3])) <<< 2)
              + (GPR_TOTAL_W'(win_reg[2]) <<< 2) + (GPR_TOTAL_W'(win_reg[2]) <<< 1);
        rounded = total + GPR_TOTAL_W'(128);
        job2 = s2_job_reg;
        job2.value = signed'(rounded[GPR_TOTAL_W-1:8]);
    end

    assign job_load = s2_emit_reg && job_free;

    gpr_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (job_load),
        .job      (job2),
        .free     (job_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_no_same_word: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_valid_reg) |-> (s1_col_reg != col_cnt_reg))
        else $error("line-store read and write-back hit the same column");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, col_cnt_reg} < WW'(MAX_WIDTH))
        else $error("column counter beyond line-store depth");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> s2_emit_reg)
        else $error("stalled pixel dropped");

    a_no_input_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !accept && !s1_valid_reg)
        else $error("sample taken during clearing pass");

endmodule

/* rtl/gpr_emit.sv */
`timescale 1ns / 1ps

module gpr_emit
    import gpr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  gpr_job_t                   job,
    output logic                       free,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // coarse_row [14:0], coarse_col [25:15], coarse_value [43:26], zero fill
    output logic [GPR_OUT_TDATA_W-1:0] m_tdata,
    output logic                       m_tlast
);

    gpr_job_t   job_reg;
    logic       busy_reg;
    logic [1:0] rpos_reg;
    logic [1:0] cpos_reg;

    logic [1:0] rend;
    logic [1:0] cend;
    logic [1:0] cstart;
    logic       last;
    logic       beat;
    logic [GPR_ROW_W-1:0] out_row;
    logic [GPR_COL_W-1:0] out_col;

    assign rend   = job_reg.bottom ? 2'd2 : 2'd1;
    assign cend   = job_reg.right  ? 2'd2 : 2'd1;
    assign cstart = job_reg.left   ? 2'd0 : 2'd1;
    assign last   = (rpos_reg == rend) && (cpos_reg == cend);
    assign beat   = busy_reg && m_tready;
    assign free   = !busy_reg || (m_tready && last);

    always_comb
    begin
        case (rpos_reg)
            2'd0:    out_row = '0;
            2'd1:    out_row = job_reg.row;
            2'd2:    out_row = job_reg.last_row;
            default: out_row = job_reg.row;
        endcase
        case (cpos_reg)
            2'd0:    out_col = '0;
            2'd1:    out_col = job_reg.col;
            2'd2:    out_col = job_reg.last_col;
            default: out_col = job_reg.col;
        endcase
    end

    assign m_tvalid = busy_reg;
    assign m_tlast  = last;
    assign m_tdata  = {4'b0000, job_reg.value, out_col, out_row};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rpos_reg <= 2'd1;
            cpos_reg <= 2'd1;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            rpos_reg <= job.top  ? 2'd0 : 2'd1;
            cpos_reg <= job.left ? 2'd0 : 2'd1;
        end
        else if (beat)
        begin
            if (last)
            begin
                busy_reg <= 1'b0;
            end
            else if (cpos_reg == cend)
            begin
                cpos_reg <= cstart;
                rpos_reg <= rpos_reg + 2'd1;
            end
            else
            begin
                cpos_reg <= cpos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= job;
        end
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("pixel loaded while a run is still open");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rpos_reg != 2'd3) && (cpos_reg != 2'd3))
        else $error("copy position out of range");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("run ended without a last beat");

endmodule

/* test/gpr_reduce_checker.sv */
`timescale 1ns / 1ps

module gpr_reduce_checker
    import gpr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [GPR_IN_TDATA_W-1:0]  s_tdata,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [GPR_OUT_TDATA_W-1:0] m_tdata,
    input  logic                       m_tlast,
    input  logic                       cfg_we,
    input  logic                       cfg_addr,
    input  logic [GPR_CFG_DATA_W-1:0]  cfg_data,
    output int                         mismatches,
    output int                         pending
);

    localparam int LINE_WORDS = 4 * GPR_MAX_WIDTH;
    localparam int COL_CNT_W  = $clog2(GPR_MAX_WIDTH);

    typedef struct {
        logic [GPR_ROW_W-1:0]           row;
        logic [GPR_COL_W-1:0]           col;
        logic signed [GPR_SAMPLE_W-1:0] value;
        logic                           last;
    } coarse_pixel_t;

    coarse_pixel_t coarse_due[$];

    logic signed [GPR_SAMPLE_W-1:0] line_rows [LINE_WORDS];
    logic signed [GPR_VSUM_W-1:0]   vsum_win [5];
    logic [GPR_FH_W-1:0]            row_pos;
    logic [COL_CNT_W-1:0]           col_pos;
    logic [GPR_FW_W-1:0]            width_reg;
    logic [GPR_FH_W-1:0]            height_reg;
    int                             bad_count;

    // advance the line stores and window by one sample, queue the pixels it completes
    function automatic void reduce_sample(input logic signed [GPR_SAMPLE_W-1:0] x);
        int unsigned w, h, r, c, cw, ch, jr, ic;
        int unsigned row_list [3];
        int unsigned col_list [3];
        int nr, nc, total, value;
        int tap [4];
        coarse_pixel_t pix;
        w = width_reg;
        h = height_reg;
        if (w < 5) w = 5;
        if (w > GPR_MAX_WIDTH) w = GPR_MAX_WIDTH;
        if (h < 5) h = 5;
        r = row_pos;
        c = col_pos;

        for (int k = 0; k < 4; k++)
            tap[k] = line_rows[((r + k) % 4) * GPR_MAX_WIDTH + c];
        line_rows[(r % 4) * GPR_MAX_WIDTH + c] = x;
        for (int k = 0; k < 4; k++)
            vsum_win[k] = vsum_win[k + 1];
        vsum_win[4] = GPR_VSUM_W'(tap[0] + 4 * (tap[1] + tap[3]) + 6 * tap[2] + x);

        cw = (w - 1) / 2 + 1;
        ch = (h - 1) / 2 + 1;
        if (r % 2 == 0 && c % 2 == 0 && r >= 4 && c >= 4 &&
            r <= 2 * ch - 2 && c <= 2 * cw - 2)
        begin
            jr = r / 2 - 1;
            ic = c / 2 - 1;
            total = vsum_win[0] + vsum_win[4] + 4 * (vsum_win[1] + vsum_win[3])
                    + 6 * vsum_win[2];
            value = (total + 128) >>> 8;
            nr = 0;
            nc = 0;
            if (jr == 1)
            begin
                row_list[nr] = 0;
                nr++;
            end
            row_list[nr] = jr;
            nr++;
            if (jr == ch - 2)
            begin
                row_list[nr] = ch - 1;
                nr++;
            end
            if (ic == 1)
            begin
                col_list[nc] = 0;
                nc++;
            end
            col_list[nc] = ic;
            nc++;
            if (ic == cw - 2)
            begin
                col_list[nc] = cw - 1;
                nc++;
            end
            for (int p = 0; p < nr; p++)
                for (int q = 0; q < nc; q++)
                begin
                    pix.row   = GPR_ROW_W'(row_list[p]);
                    pix.col   = GPR_COL_W'(col_list[q]);
                    pix.value = GPR_SAMPLE_W'(value);
                    pix.last  = (p == nr - 1) && (q == nc - 1);
                    coarse_due.push_back(pix);
                end
        end

        if (c + 1 >= w)
        begin
            col_pos = '0;
            row_pos = (r + 1 >= h) ? '0 : GPR_FH_W'(r + 1);
        end
        else
            col_pos = COL_CNT_W'(c + 1);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        coarse_pixel_t want, got;
        if (!rst_n)
        begin
            foreach (line_rows[k])
                line_rows[k] = '0;
            foreach (vsum_win[k])
                vsum_win[k] = '0;
            row_pos    = '0;
            col_pos    = '0;
            width_reg  = GPR_WIDTH_RESET;
            height_reg = GPR_HEIGHT_RESET;
            coarse_due.delete();
            bad_count  = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            // compare before predicting, so a beat can never match work queued this edge
            if (m_tvalid && m_tready)
            begin
                got.row   = m_tdata[GPR_ROW_W-1:0];
                got.col   = m_tdata[GPR_ROW_W +: GPR_COL_W];
                got.value = m_tdata[GPR_ROW_W + GPR_COL_W +: GPR_SAMPLE_W];
                got.last  = m_tlast;
                if (coarse_due.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("%0t: unexpected beat row %0d col %0d value %0d last %0b",
                                 $time, got.row, got.col, got.value, got.last);
                end
                else
                begin
                    want = coarse_due.pop_front();
                    if (got.row !== want.row || got.col !== want.col ||
                        got.value !== want.value || got.last !== want.last)
                    begin
                        bad_count++;
                        if (bad_count <= 10)
                            $display({"%0t: mismatch exp row %0d col %0d value %0d last %0b,",
                                      " got row %0d col %0d value %0d last %0b"},
                                     $time, want.row, want.col, want.value, want.last,
                                     got.row, got.col, got.value, got.last);
                    end
                end
            end

            if (cfg_we)
            begin
                if (cfg_addr == REG_FRAME_WIDTH)
                    width_reg = cfg_data[GPR_FW_W-1:0];
                else
                    height_reg = cfg_data[GPR_FH_W-1:0];
            end

            if (s_tvalid && s_tready)
                reduce_sample(s_tdata[GPR_SAMPLE_W-1:0]);

            mismatches <= bad_count;
            pending    <= coarse_due.size();
        end
    end

endmodule

/* test/tb_gaussian_pyramid_reduce_unit.sv */
`timescale 1ns / 1ps

module tb_gaussian_pyramid_reduce_unit;
    import gpr_pkg::*;

    localparam int ITEM_BUDGET = 270;
    // last stretch of samples runs without any idling on either side
    localparam int CALM_TAIL   = 40;
    // three pipeline stages; extra wait so samples that emit nothing clear the pipe
    localparam int DRAIN       = 8;
    // clearing pass over 4096 words plus ~300 samples at worst case of 9 stalled beats each, with slack
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [GPR_SAMPLE_W-1:0] SAMPLE_MAX = 18'h1FFFF;
    localparam logic [GPR_SAMPLE_W-1:0] SAMPLE_MIN = 18'h20000;

    logic                       clk;
    logic                       rst_n;
    logic                       s_tvalid;
    logic                       s_tready;
    // sample_in [17:0], zero fill
    logic [GPR_IN_TDATA_W-1:0]  s_tdata;
    logic                       m_tvalid;
    logic                       m_tready;
    // coarse_row [14:0], coarse_col [25:15], coarse_value [43:26], zero fill
    logic [GPR_OUT_TDATA_W-1:0] m_tdata;
    logic                       m_tlast;
    logic                       cfg_we;
    logic                       cfg_addr;
    logic [GPR_CFG_DATA_W-1:0]  cfg_data;

    int mismatches;
    int pending;
    int cycle_count = 0;
    bit calm = 1'b0;

    gaussian_pyramid_reduce_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    // predicts every coarse pixel from the accepted samples and checks the output beats
    gpr_reduce_checker reduce_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop in case the block hangs or drops beats
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // output side: stall in random bursts between ready stretches
    initial
    begin
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    // mostly plain random data, with a good share of the field extremes, zero and all ones; flat runs hold one level
    function automatic logic [GPR_SAMPLE_W-1:0] pick_sample(input bit flat,
                                                           input logic [GPR_SAMPLE_W-1:0] level);
        if (flat)
            return level;
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            3:       return '1;
            default: return GPR_SAMPLE_W'($urandom);
        endcase
    endfunction

    // hold one sample on the input until it is taken; sometimes idle first
    task automatic send_sample(input logic [GPR_SAMPLE_W-1:0] v);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(GPR_IN_TDATA_W - GPR_SAMPLE_W){1'b0}}, v};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_run(input int count, input bit flat,
                            input logic [GPR_SAMPLE_W-1:0] level);
        repeat (count)
            send_sample(pick_sample(flat, level));
        s_tvalid <= 1'b0;
    endtask

    // write width then height on back-to-back edges; junk above the width field must be ignored
    task automatic set_frame(input logic [GPR_FW_W-1:0] w, input logic [GPR_FH_W-1:0] h);
        logic [GPR_CFG_DATA_W-1:0] wdata;
        wdata = GPR_CFG_DATA_W'($urandom);
        wdata[GPR_FW_W-1:0] = w;
        cfg_we   <= 1'b1;
        cfg_addr <= REG_FRAME_WIDTH;
        cfg_data <= wdata;
        @(posedge clk);
        cfg_addr <= REG_FRAME_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait until every predicted pixel is out, then let silent samples clear the pipe
    task automatic settle();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    initial
    begin
        int w, h, n, kind, fed;
        bit flat;
        logic [GPR_SAMPLE_W-1:0] level;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        cfg_we   <= 1'b0;
        cfg_addr <= REG_FRAME_WIDTH;
        cfg_data <= '0;
        fed = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: width and height below the minimum clamp to a 5x5 frame.
        // A full-scale flat frame drives the rounded sum to its top value and
        // the single interior pixel fans out to all nine border copies.
        set_frame(GPR_FW_W'(2), GPR_FH_W'(0));
        send_run(25, 1'b1, SAMPLE_MAX);
        fed += 25;

        while (fed < ITEM_BUDGET)
        begin
            settle();
            kind  = $urandom_range(0, 9);
            flat  = ($urandom_range(0, 5) == 0);
            level = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            case (kind)
                0:
                begin
                    // wide line: widths at or past the maximum clamp, counters
                    // left mid-row so the next setting wraps them at once
                    w = $urandom_range(0, 1) ? GPR_MAX_WIDTH
                                             : $urandom_range(GPR_MAX_WIDTH + 1, 8191);
                    h = $urandom_range(0, 1) ? 65535 : $urandom_range(5, 9);
                    n = $urandom_range(3, 12);
                end
                1:
                begin
                    // tallest frame, or a height below the minimum
                    w = $urandom_range(5, 9);
                    h = $urandom_range(0, 1) ? 65535 : $urandom_range(0, 4);
                    n = w * $urandom_range(5, 9);
                end
                default:
                begin
                    // small frames, some with a width below the minimum; one full frame of samples
                    w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4)
                                                    : $urandom_range(5, 9);
                    h = $urandom_range(5, 9);
                    n = ((w < 5) ? 5 : w) * h;
                end
            endcase
            if (fed + n > ITEM_BUDGET - CALM_TAIL)
                calm = 1'b1;
            set_frame(GPR_FW_W'(w), GPR_FH_W'(h));
            send_run(n, flat, level);
            fed += n;
        end

        settle();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/gpr_pkg.sv
rtl/gpr_emit.sv
rtl/gaussian_pyramid_reduce_unit.sv
test/gpr_reduce_checker.sv
test/tb_gaussian_pyramid_reduce_unit.sv
